// ===== src/kvrt_pkg.sv =====
// kvrt_pkg: shared types and codes for the key/value record tokenizer
// used by the front classifier, the item queue, the back parser and the top level

package kvrt_pkg;

  localparam int KVRT_MAX_FIELDS = 16;
  localparam int KVRT_KEY_SIZE   = 16;
  localparam int KVRT_VALUE_SIZE = 32;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // result role codes
  localparam logic [2:0] ROLE_NONE = 3'd0;
  localparam logic [2:0] ROLE_TYPE = 3'd1;
  localparam logic [2:0] ROLE_KEY  = 3'd2;
  localparam logic [2:0] ROLE_EQ   = 3'd3;
  localparam logic [2:0] ROLE_VAL  = 3'd4;

  // line status codes
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_OK     = 2'd1;
  localparam logic [1:0] ST_BLANK  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // character class flags worked out by the front
  typedef struct packed {
    logic zero;
    logic nl;
    logic cr;
    logic blank;   // space or tab
    logic ws;      // space, tab, newline, vtab, form feed, cr
    logic alnum;
    logic hash;
    logic eq;
  } cls_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    cls_t       cls;
  } item_t;

endpackage

// ===== src/kvrt_front.sv =====
// kvrt_front: classifies each incoming character into the flags the parser uses
// depends on kvrt_pkg

module kvrt_front (
  input  logic [7:0]     in_ch,
  input  logic           in_line_end,
  output kvrt_pkg::item_t item
);
  import kvrt_pkg::*;

  cls_t cls;

  always_comb begin
    cls.zero  = (in_ch == CH_NUL);
    cls.nl    = (in_ch == CH_NL);
    cls.cr    = (in_ch == CH_CR);
    cls.blank = (in_ch == CH_SPACE) || (in_ch == CH_TAB);
    cls.ws    = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
    cls.alnum = ((in_ch >= 8'h30) && (in_ch <= 8'h39)) ||
                ((in_ch >= 8'h41) && (in_ch <= 8'h5A)) ||
                ((in_ch >= 8'h61) && (in_ch <= 8'h7A));
    cls.hash  = (in_ch == CH_HASH);
    cls.eq    = (in_ch == CH_EQ);
  end

  assign item.ch       = in_ch;
  assign item.line_end = in_line_end;
  assign item.cls      = cls;

endmodule

// ===== src/kvrt_queue.sv =====
// kvrt_queue: two-entry item queue between the front classifier and the back parser
// depends on kvrt_pkg

module kvrt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kvrt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output kvrt_pkg::item_t head
);
  import kvrt_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/kvrt_back.sv =====
// kvrt_back: line parser state and registered result stage
// depends on kvrt_pkg; takes classified items from kvrt_queue

module kvrt_back #(
  parameter int MAX_FIELDS = kvrt_pkg::KVRT_MAX_FIELDS,
  parameter int KEY_SIZE   = kvrt_pkg::KVRT_KEY_SIZE,
  parameter int VALUE_SIZE = kvrt_pkg::KVRT_VALUE_SIZE
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  kvrt_pkg::item_t item,
  output logic            item_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_char_echo,
  output logic [2:0]      out_role,
  output logic [3:0]      out_field_index,
  output logic [4:0]      out_char_pos,
  output logic            out_done_res,
  output logic [1:0]      out_status,
  output logic [4:0]      out_field_count
);
  import kvrt_pkg::*;

  localparam int KW = $clog2(KEY_SIZE);
  localparam int VW = $clog2(VALUE_SIZE);
  localparam int FW = $clog2(MAX_FIELDS + 1);

  localparam logic [KW-1:0] KEY_LAST = KW'(KEY_SIZE - 1);
  localparam logic [VW-1:0] VAL_LAST = VW'(VALUE_SIZE - 1);
  localparam logic [FW-1:0] FD_MAX   = FW'(MAX_FIELDS);

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_SEP   = 3'd2;
  localparam logic [2:0] PH_KEY   = 3'd3;
  localparam logic [2:0] PH_VAL   = 3'd4;
  localparam logic [2:0] PH_OK    = 3'd5;
  localparam logic [2:0] PH_BLANK = 3'd6;
  localparam logic [2:0] PH_ERR   = 3'd7;

  typedef struct packed {
    logic [2:0]    ph;
    logic [1:0]    tl;
    logic [KW-1:0] kl;
    logic [VW-1:0] vl;
    logic [FW-1:0] fd;
  } pst_t;

  typedef struct packed {
    pst_t       s;
    logic [2:0] role;
    logic [7:0] idx;
    logic [7:0] pos;
  } step_t;

  // separator handling, shared by type end, value end and separator phase
  function automatic step_t sep_char(step_t r, cls_t c);
    step_t o;
    o = r;
    if (c.blank) begin
      o = r;
    end else if (c.zero || c.nl || c.cr) begin
      o.s.ph = PH_OK;
    end else if (c.ws || (r.s.fd >= FD_MAX) || c.eq) begin
      o.s.ph = PH_ERR;
    end else begin
      o.role = ROLE_KEY;
      o.idx  = 8'(r.s.fd);
      o.pos  = 8'd0;
      o.s.kl = KW'(1);
      o.s.vl = '0;
      o.s.ph = PH_KEY;
    end
    return o;
  endfunction

  function automatic step_t take_char(pst_t s, cls_t c);
    step_t o;
    o.s    = s;
    o.role = ROLE_NONE;
    o.idx  = 8'd0;
    o.pos  = 8'd0;
    unique case (s.ph)
      PH_LEAD: begin
        if (c.blank) begin
          o.s.ph = PH_LEAD;
        end else if (c.zero || c.nl || c.hash) begin
          o.s.ph = PH_BLANK;
        end else if (c.alnum) begin
          o.role = ROLE_TYPE;
          o.s.tl = 2'd1;
          o.s.ph = PH_TYPE;
        end else begin
          o.s.ph = PH_ERR;
        end
      end
      PH_TYPE: begin
        if (c.alnum) begin
          if (s.tl < 2'd3) begin
            o.role = ROLE_TYPE;
            o.pos  = 8'(s.tl);
            o.s.tl = s.tl + 2'd1;
          end else begin
            o.s.ph = PH_ERR;
          end
        end else if (c.zero || c.ws) begin
          o.s.ph = PH_SEP;
          o = sep_char(o, c);
        end else begin
          o.s.ph = PH_ERR;
        end
      end
      PH_SEP: begin
        o = sep_char(o, c);
      end
      PH_KEY: begin
        if (c.zero || c.ws || (c.eq && (s.kl == '0))) begin
          o.s.ph = PH_ERR;
        end else if (c.eq) begin
          o.role = ROLE_EQ;
          o.idx  = 8'(s.fd);
          o.s.vl = '0;
          o.s.ph = PH_VAL;
        end else if (s.kl >= KEY_LAST) begin
          o.s.ph = PH_ERR;
        end else begin
          o.role = ROLE_KEY;
          o.idx  = 8'(s.fd);
          o.pos  = 8'(s.kl);
          o.s.kl = s.kl + KW'(1);
        end
      end
      PH_VAL: begin
        if (c.zero || c.ws) begin
          o.s.fd = s.fd + FW'(1);
          o.s.ph = PH_SEP;
          o = sep_char(o, c);
        end else if (s.vl >= VAL_LAST) begin
          o.s.ph = PH_ERR;
        end else begin
          o.role = ROLE_VAL;
          o.idx  = 8'(s.fd);
          o.pos  = 8'(s.vl);
          o.s.vl = s.vl + VW'(1);
        end
      end
      default: begin
        o.s = s;
      end
    endcase
    return o;
  endfunction

  pst_t       st_r;
  pst_t       st_nxt;
  step_t      first;
  step_t      second;
  pst_t       fin;
  cls_t       nul_cls;
  logic [1:0] status;

  logic       out_valid_r;
  logic [7:0] char_r;
  logic [2:0] role_r;
  logic [3:0] idx_r;
  logic [4:0] pos_r;
  logic       done_r;
  logic [1:0] status_r;
  logic [4:0] count_r;

  assign item_take = item_valid && (!out_valid_r || !out_stall);

  always_comb begin
    nul_cls       = '0;
    nul_cls.zero  = 1'b1;
    first         = take_char(st_r, item.cls);
    // an unterminated last item is closed as if a nul followed
    second        = take_char(first.s, nul_cls);
    if (item.line_end && (first.s.ph < PH_OK)) begin
      fin = second.s;
    end else begin
      fin = first.s;
    end
    unique case (fin.ph)
      PH_OK:    status = ST_OK;
      PH_BLANK: status = ST_BLANK;
      PH_ERR:   status = ST_REJECT;
      default:  status = ST_BUSY;
    endcase
    if (item.line_end) begin
      st_nxt    = '0;
      st_nxt.ph = PH_LEAD;
    end else begin
      st_nxt = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        st_r <= st_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      char_r   <= item.ch;
      role_r   <= first.role;
      idx_r    <= first.idx[3:0];
      pos_r    <= first.pos[4:0];
      done_r   <= item.line_end;
      status_r <= status;
      count_r  <= 5'(fin.fd);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_echo   = char_r;
  assign out_role        = role_r;
  assign out_field_index = idx_r;
  assign out_char_pos    = pos_r;
  assign out_done_res    = done_r;
  assign out_status      = status_r;
  assign out_field_count = count_r;

endmodule

// ===== src/key_value_record_tokenizer.sv =====
// key_value_record_tokenizer: top level of the record line tokenizer
// depends on kvrt_pkg, kvrt_front, kvrt_queue and kvrt_back

// Takes one character of a "TYPE key=value ..." text line per item and returns
// one result item per input item, tagging the character as type, key, '=' or
// value, with its field index and position. The item flagged line_end carries
// the final line status and field count, and the parser then rearms for the
// next line. One item is taken per clock cycle in steady state while the
// result side is not stalled: the parser state in the back stage is updated
// from each item as it is taken, so the per-line state loop sets the rate. An
// accepted item is written into the queue and then into the registered result
// stage, from which it is offered on the result channel. A two-entry queue between the
// classifier and the parser and a registered result stage let either side
// stall without holding up the other beyond the queue depth.

module key_value_record_tokenizer #(
  parameter int MAX_FIELDS = kvrt_pkg::KVRT_MAX_FIELDS,
  parameter int KEY_SIZE   = kvrt_pkg::KVRT_KEY_SIZE,
  parameter int VALUE_SIZE = kvrt_pkg::KVRT_VALUE_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_line_end,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_echo,
  output logic [2:0] out_role,
  output logic [3:0] out_field_index,
  output logic [4:0] out_char_pos,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [4:0] out_field_count
);
  import kvrt_pkg::*;

  item_t in_item;     // classified incoming item
  item_t q_head;      // oldest queued item
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  q_push;

  // front: tag each character with its class flags
  kvrt_front u_front (
    .in_ch       (in_ch),
    .in_line_end (in_line_end),
    .item        (in_item)
  );

  // input side stalls only when the queue holds two items
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  kvrt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: parser state update and registered result
  kvrt_back #(
    .MAX_FIELDS (MAX_FIELDS),
    .KEY_SIZE   (KEY_SIZE),
    .VALUE_SIZE (VALUE_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (q_not_empty),
    .item            (q_head),
    .item_take       (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_echo   (out_char_echo),
    .out_role        (out_role),
    .out_field_index (out_field_index),
    .out_char_pos    (out_char_pos),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_field_count (out_field_count)
  );

endmodule

// ===== bench/kvrt_tag_check_pkg.sv =====
// kvrt_tag_check_pkg: line tag predictor and result scoreboard for the record tokenizer bench
// depends on kvrt_pkg for character, role and status codes

package kvrt_tag_check_pkg;
  import kvrt_pkg::*;

  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_TYPE, SCAN_GAP, SCAN_KEY, SCAN_VALUE,
    LINE_OK, LINE_BLANK, LINE_REJECT
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] char_echo;
    logic [2:0] role;
    logic [3:0] field_index;
    logic [4:0] char_pos;
    logic       done_res;
    logic [1:0] status;
    logic [4:0] field_count;
  } char_tag_t;

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // space plus tab through carriage return
  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  class line_tag_scoreboard;
    scan_phase_e phase;
    logic [1:0]  type_len;
    logic [4:0]  key_len;
    logic [5:0]  value_len;
    logic [4:0]  fields_done;
    char_tag_t   pending_tags[$];
    int          mismatches;

    function new();
      rearm();
      mismatches = 0;
    endfunction

    function void rearm();
      phase       = SCAN_LEAD;
      type_len    = '0;
      key_len     = '0;
      value_len   = '0;
      fields_done = '0;
    endfunction

    // between tokens: blanks skip, terminators close the line, anything else opens a key
    function void gap_char(logic [7:0] c, inout char_tag_t t);
      if (c == CH_SPACE || c == CH_TAB) begin
      end else if (c == CH_NUL || c == CH_NL || c == CH_CR) begin
        phase = LINE_OK;
      end else if (is_ws(c) || fields_done >= KVRT_MAX_FIELDS || c == CH_EQ) begin
        phase = LINE_REJECT;
      end else begin
        t.role        = ROLE_KEY;
        t.field_index = fields_done[3:0];
        t.char_pos    = '0;
        key_len       = 5'd1;
        value_len     = '0;
        phase         = SCAN_KEY;
      end
    endfunction

    function void take_char(logic [7:0] c, inout char_tag_t t);
      case (phase)
        SCAN_LEAD: begin
          if (c == CH_SPACE || c == CH_TAB) begin
          end else if (c == CH_NUL || c == CH_NL || c == CH_HASH) begin
            phase = LINE_BLANK;
          end else if (is_alnum(c)) begin
            t.role     = ROLE_TYPE;
            t.char_pos = '0;
            type_len   = 2'd1;
            phase      = SCAN_TYPE;
          end else begin
            phase = LINE_REJECT;
          end
        end
        SCAN_TYPE: begin
          if (is_alnum(c)) begin
            if (type_len < 2'd3) begin
              t.role     = ROLE_TYPE;
              t.char_pos = 5'(type_len);
              type_len   = type_len + 2'd1;
            end else begin
              phase = LINE_REJECT;
            end
          end else if (c == CH_NUL || is_ws(c)) begin
            phase = SCAN_GAP;
            gap_char(c, t);
          end else begin
            phase = LINE_REJECT;
          end
        end
        SCAN_GAP: gap_char(c, t);
        SCAN_KEY: begin
          if (c == CH_NUL || is_ws(c) || (c == CH_EQ && key_len == 0)) begin
            phase = LINE_REJECT;
          end else if (c == CH_EQ) begin
            t.role        = ROLE_EQ;
            t.field_index = fields_done[3:0];
            value_len     = '0;
            phase         = SCAN_VALUE;
          end else if (int'(key_len) + 1 >= KVRT_KEY_SIZE) begin
            phase = LINE_REJECT;
          end else begin
            t.role        = ROLE_KEY;
            t.field_index = fields_done[3:0];
            t.char_pos    = key_len;
            key_len       = key_len + 5'd1;
          end
        end
        SCAN_VALUE: begin
          if (c == CH_NUL || is_ws(c)) begin
            fields_done = fields_done + 5'd1;
            phase       = SCAN_GAP;
            gap_char(c, t);
          end else if (int'(value_len) + 1 >= KVRT_VALUE_SIZE) begin
            phase = LINE_REJECT;
          end else begin
            t.role        = ROLE_VAL;
            t.field_index = fields_done[3:0];
            t.char_pos    = value_len[4:0];
            value_len     = value_len + 6'd1;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic last);
      char_tag_t t;
      char_tag_t unused;
      t = '0;
      unused = '0;
      t.char_echo = c;
      take_char(c, t);
      if (last && phase < LINE_OK) take_char(CH_NUL, unused);
      case (phase)
        LINE_OK:     t.status = ST_OK;
        LINE_BLANK:  t.status = ST_BLANK;
        LINE_REJECT: t.status = ST_REJECT;
        default:     t.status = ST_BUSY;
      endcase
      t.done_res    = last;
      t.field_count = fields_done;
      pending_tags.push_back(t);
      if (last) rearm();
    endfunction

    function void check_tag(char_tag_t got);
      char_tag_t want;
      if (pending_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item, char 0x%02h", got.char_echo);
      end else begin
        want = pending_tags.pop_front();
        if (got.char_echo !== want.char_echo || got.role !== want.role ||
            got.field_index !== want.field_index || got.char_pos !== want.char_pos ||
            got.done_res !== want.done_res || got.status !== want.status ||
            got.field_count !== want.field_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tag mismatch: got echo %02h role %0d field %0d pos %0d",
                     got.char_echo, got.role, got.field_index, got.char_pos,
                     " done %0b status %0d count %0d", got.done_res, got.status,
                     got.field_count,
                     " / expected echo %02h role %0d field %0d pos %0d",
                     want.char_echo, want.role, want.field_index, want.char_pos,
                     " done %0b status %0d count %0d", want.done_res, want.status,
                     want.field_count);
        end
      end
    endfunction

    function int failure_count();
      return mismatches + pending_tags.size();
    endfunction
  endclass

endpackage

// ===== bench/key_value_record_tokenizer_tb.sv =====
// key_value_record_tokenizer_tb: feeds record lines one character per item and checks every tag
// depends on kvrt_pkg, kvrt_tag_check_pkg and the key_value_record_tokenizer rtl

module key_value_record_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvrt_pkg::*;
  import kvrt_tag_check_pkg::*;

  typedef logic [7:0] char_q_t[$];

  localparam int CYCLE_LIMIT  = 50000;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_CYCLES = 10;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch       = '0;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_char_echo;
  logic [2:0] out_role;
  logic [3:0] out_field_index;
  logic [4:0] out_char_pos;
  logic       out_done_res;
  logic [1:0] out_status;
  logic [4:0] out_field_count;

  line_tag_scoreboard tags;
  char_tag_t          seen_tag;
  int unsigned        cycle_count   = 0;
  int unsigned        sent_items    = 0;
  int unsigned        taken_results = 0;
  bit                 hold_off_done = 1'b0;

  key_value_record_tokenizer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_echo   (out_char_echo),
    .out_role        (out_role),
    .out_field_index (out_field_index),
    .out_char_pos    (out_char_pos),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_field_count (out_field_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // every accepted result item goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_tag.char_echo   = out_char_echo;
      seen_tag.role        = out_role;
      seen_tag.field_index = out_field_index;
      seen_tag.char_pos    = out_char_pos;
      seen_tag.done_res    = out_done_res;
      seen_tag.status      = out_status;
      seen_tag.field_count = out_field_count;
      tags.check_tag(seen_tag);
      taken_results <= taken_results + 1;
    end
  end

  // result side: random stalls, one long hold-off to back the block up,
  // and a steady stretch with no stalls at all
  initial begin : result_side
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_off_done && taken_results >= 100) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (taken_results >= 200 && taken_results < 320) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 26);
    end
  end

  // ---------------------------------------------------------------------
  // character pickers
  // ---------------------------------------------------------------------

  function automatic char_q_t text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] alnum_char();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  // any non-blank, non-zero byte; '=' only where asked for
  function automatic logic [7:0] token_char(bit allow_eq);
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (c == CH_EQ && !allow_eq);
    return c;
  endfunction

  // half the time a character the parser treats specially
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 19))
      0:       return CH_NUL;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return CH_VTAB;
      4:       return CH_FF;
      5:       return CH_CR;
      6:       return CH_SPACE;
      7:       return CH_HASH;
      8:       return CH_EQ;
      9:       return alnum_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random line: mostly well-formed records with random content,
  // some blank or comment lines, some raw noise
  function automatic char_q_t make_line();
    char_q_t q;
    int      kind;
    int      pick;
    int      nfields;
    int      klen;
    int      vlen;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) q.push_back(blank_char());
    if (kind < 12) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        q.push_back(CH_NL);
      end
    end else if (kind < 30) begin
      repeat ($urandom_range(1, 12)) q.push_back(noise_char());
    end else begin
      // type, now and then too long or with a stray character behind it
      repeat (($urandom_range(0, 15) == 0) ? 4 : $urandom_range(1, 3))
        q.push_back(alnum_char());
      if ($urandom_range(0, 19) == 0) q.push_back(noise_char());
      // a full field table or one past it now and then
      pick = $urandom_range(0, 19);
      if (pick == 0) nfields = KVRT_MAX_FIELDS;
      else if (pick == 1) nfields = KVRT_MAX_FIELDS + 1;
      else nfields = $urandom_range(0, 4);
      for (int f = 0; f < nfields; f++) begin
        repeat ($urandom_range(1, 2)) q.push_back(blank_char());
        if (nfields > 4) begin
          klen = $urandom_range(1, 2);
          vlen = $urandom_range(0, 2);
        end else begin
          // keys and values near their size limits, and the odd empty key
          klen = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 16) : $urandom_range(1, 5);
          vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 32) : $urandom_range(0, 6);
          if ($urandom_range(0, 29) == 0) klen = 0;
        end
        repeat (klen) q.push_back(token_char(1'b0));
        // rare token with no '='
        if ($urandom_range(0, 29) != 0) q.push_back(CH_EQ);
        repeat (vlen) q.push_back(token_char(1'b1));
      end
      // terminator; value 5 leaves the line unterminated
      case ($urandom_range(0, 5))
        0: q.push_back(CH_NL);
        1: q.push_back(CH_CR);
        2: q.push_back(CH_NUL);
        3: begin
          repeat ($urandom_range(1, 3)) q.push_back(blank_char());
          q.push_back(CH_NL);
        end
        4: begin
          // characters after the end of the line
          q.push_back(CH_NL);
          repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
        end
      endcase
    end
    if (q.size() == 0) q.push_back(CH_NUL);
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // one character item, with random gaps outside the steady stretch
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!(sent_items >= 200 && sent_items < 300) && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_line_end <= last;
    do @(posedge clk); while (in_stall);
    tags.note_char(c, last);
    sent_items++;
    @(negedge clk);
  endtask

  // the last character of the line carries line_end
  task automatic send_line(input char_q_t chars);
    for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  // stop offering until every expected item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tags.pending_tags.size() != 0);
  endtask

  initial begin : stimulus
    char_q_t line;
    bit      paused;
    tags   = new();
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines
    // full record left unterminated: type, key, '=', value
    send_line(text("AB x=1"));
    // comment, then a character after the line is done, all ones
    line = text("#");
    line.push_back(8'hFF);
    send_line(line);
    // a lone zero ends an empty line
    line = {};
    line.push_back(CH_NUL);
    send_line(line);
    // vertical tab where a token would start
    line = text("A ");
    line.push_back(CH_VTAB);
    send_line(line);
    // type followed by a non-blank
    send_line(text("A="));
    // token with no '=' cut by a carriage return
    line = text("Ab k");
    line.push_back(CH_CR);
    send_line(line);
    // carriage return as the first non-blank
    line = {};
    line.push_back(CH_CR);
    send_line(line);
    // form feed after a complete field
    line = text("z\tk=v");
    line.push_back(CH_FF);
    send_line(line);
    wait_drained();

    // random lines
    while (sent_items < RANDOM_ITEMS + 26) begin
      if (!paused && sent_items >= 350) begin
        paused = 1'b1;
        wait_drained();
      end
      send_line(make_line());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tags.failure_count() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
